/* sv/edge_length_clamp_projection_assert.svh */
// Assertion macros used by the edge length clamp projection checker.
`ifndef EDGE_LENGTH_CLAMP_PROJECTION_ASSERT_SVH
`define EDGE_LENGTH_CLAMP_PROJECTION_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ELCP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("elcp assertion failed");

// Next-cycle implication, ignored while reset is asserted.
`define ELCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("elcp assertion failed");

// Same-cycle implication that also holds through reset.
`define ELCP_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("elcp assertion failed");

`endif

/* sv/elcp_pkg.sv */
// Shared widths and constants of the edge length clamp projection block.
package elcp_pkg;
    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W;
    localparam int RAD_W   = SQ_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int WGT_W   = 24;
    localparam int WM_W    = WGT_W + DIFF_W;
    localparam int LO_W    = 29;
    localparam int NUM_W   = WM_W + COORD_W;
    localparam int FRAC_SH = 17;
    localparam int QN_W    = NUM_W - FRAC_SH;
    localparam int Q_W     = 32;
    localparam int LANES   = 3;

    localparam logic [1:0] REG_RANGE_MIN = 2'd0;
    localparam logic [1:0] REG_RANGE_MAX = 2'd1;
    localparam logic [1:0] REG_WEIGHT    = 2'd2;

    localparam logic [Q_W-1:0] MAG_CAP = {1'b1, {(Q_W-1){1'b0}}};
endpackage

/* sv/elcp_sqrt.sv */
// Pipelined digit-by-digit square root, one result bit per stage.
module elcp_sqrt #(
    parameter int SIDE_W = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [elcp_pkg::RAD_W-1:0]   i_rad,
    input  logic [SIDE_W-1:0]            i_side,
    output logic                         o_valid,
    output logic [elcp_pkg::ROOT_W-1:0]  o_root,
    output logic [SIDE_W-1:0]            o_side
);
    import elcp_pkg::*;

    localparam int PAD_W = 2 * ROOT_W;

    logic                r_v    [0:ROOT_W-1];
    logic [REM_W-1:0]    r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0]   r_root [0:ROOT_W-1];
    logic [PAD_W-1:0]    r_rad  [0:ROOT_W-1];
    logic [SIDE_W-1:0]   r_side [0:ROOT_W-1];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_st
        logic              a_v;
        logic [REM_W-1:0]  a_rem;
        logic [ROOT_W-1:0] a_root;
        logic [PAD_W-1:0]  a_rad;
        logic [SIDE_W-1:0] a_side;
        logic [REM_W-1:0]  sh;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign a_v    = i_valid;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_rad  = PAD_W'(i_rad);
            assign a_side = i_side;
        end else begin : g_next
            assign a_v    = r_v[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_rad  = r_rad[k-1];
            assign a_side = r_side[k-1];
        end

        // Bring down the next pair of radicand bits and try root*4+1.
        assign sh    = {a_rem[REM_W-3:0], a_rad[2*(ROOT_W-1-k)+1 -: 2]};
        assign trial = {1'b0, a_root, 2'b01};
        assign ge    = (sh >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? (sh - trial) : sh;
                r_root[k] <= {a_root[ROOT_W-2:0], ge};
                r_rad[k]  <= a_rad;
                r_side[k] <= a_side;
            end
        end
    end

    assign o_valid = r_v[ROOT_W-1];
    assign o_root  = r_root[ROOT_W-1];
    assign o_side  = r_side[ROOT_W-1];
endmodule

/* sv/elcp_div.sv */
// Pipelined restoring divider for three lanes sharing one divisor, capped quotient.
module elcp_div #(
    parameter int SIDE_W = 4
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic                                            i_en,
    input  logic                                            i_valid,
    input  logic [elcp_pkg::LANES-1:0][elcp_pkg::QN_W-1:0]  i_num,
    input  logic [elcp_pkg::ROOT_W-1:0]                     i_den,
    input  logic [SIDE_W-1:0]                               i_side,
    output logic                                            o_valid,
    output logic [elcp_pkg::LANES-1:0][elcp_pkg::Q_W-1:0]   o_mag,
    output logic [SIDE_W-1:0]                               o_side
);
    import elcp_pkg::*;

    localparam int HI_W = QN_W - Q_W;

    logic                               r_v    [0:Q_W];
    logic [ROOT_W-1:0]                  r_den  [0:Q_W];
    logic [SIDE_W-1:0]                  r_side [0:Q_W];
    logic [LANES-1:0]                   r_ovf  [0:Q_W];
    logic [LANES-1:0][ROOT_W-1:0]       r_rem  [0:Q_W];
    logic [LANES-1:0][Q_W-1:0]          r_lo   [0:Q_W];
    logic [LANES-1:0][Q_W-1:0]          r_q    [0:Q_W];

    // Setup stage: a quotient of 2^32 or more is flagged here and capped later.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_side[0] <= i_side;
            for (int l = 0; l < LANES; l++) begin
                r_ovf[0][l] <= (i_num[l][QN_W-1:Q_W] >= HI_W'(i_den));
                r_rem[0][l] <= i_num[l][Q_W+ROOT_W-1:Q_W];
                r_lo[0][l]  <= i_num[l][Q_W-1:0];
                r_q[0][l]   <= '0;
            end
        end
    end

    for (genvar k = 1; k <= Q_W; k++) begin : g_st
        logic [LANES-1:0][ROOT_W:0]   sh;
        logic [LANES-1:0]             ge;
        logic [LANES-1:0][ROOT_W:0]   diff;

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                sh[l]   = {r_rem[k-1][l], r_lo[k-1][l][Q_W-k]};
                ge[l]   = (sh[l] >= {1'b0, r_den[k-1]});
                diff[l] = sh[l] - {1'b0, r_den[k-1]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[k]  <= r_den[k-1];
                r_side[k] <= r_side[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_lo[k]   <= r_lo[k-1];
                for (int l = 0; l < LANES; l++) begin
                    r_rem[k][l] <= ge[l] ? diff[l][ROOT_W-1:0] : sh[l][ROOT_W-1:0];
                    r_q[k][l]   <= {r_q[k-1][l][Q_W-2:0], ge[l]};
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            o_mag[l] = (r_ovf[Q_W][l] || (r_q[Q_W][l] > MAG_CAP)) ? MAG_CAP : r_q[Q_W][l];
        end
    end

    assign o_valid = r_v[Q_W];
    assign o_side  = r_side[Q_W];
endmodule

/* sv/edge_length_clamp_projection.sv */
// Edge length clamp projection: accepts one edge (two Q16.16 points) per clock and
// returns both weighted projection rows through the 33-stage square root and the
// 33-stage divider, with four stages for the difference, magnitude, square and sum,
// three for clamp and the split product, and one output register. The whole
// pipeline holds in place while a result waits to be taken.
module edge_length_clamp_projection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic signed [31:0] i_p0_x,
    input  logic signed [31:0] i_p0_y,
    input  logic signed [31:0] i_p0_z,
    input  logic signed [31:0] i_p1_x,
    input  logic signed [31:0] i_p1_y,
    input  logic signed [31:0] i_p1_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic signed [31:0] o_proj0_x,
    output logic signed [31:0] o_proj0_y,
    output logic signed [31:0] o_proj0_z,
    output logic signed [31:0] o_proj1_x,
    output logic signed [31:0] o_proj1_y,
    output logic signed [31:0] o_proj1_z
);
    import elcp_pkg::*;

    localparam int HI_PART_W = WM_W - LO_W;
    localparam int SQS_W     = LANES + LANES * WM_W;

    logic [COORD_W-1:0] r_rmin;
    logic [COORD_W-1:0] r_rmax;
    logic [WGT_W-1:0]   r_weight;

    logic en;

    logic                               r1_v;
    logic [LANES-1:0][DIFF_W-1:0]       r1_d;
    logic                               r2_v;
    logic [LANES-1:0][DIFF_W-1:0]       r2_mag;
    logic [LANES-1:0]                   r2_neg;
    logic                               r3_v;
    logic [LANES-1:0][SQ_W-1:0]         r3_sq;
    logic [LANES-1:0][WM_W-1:0]         r3_wm;
    logic [LANES-1:0]                   r3_neg;
    logic                               r4_v;
    logic [RAD_W-1:0]                   r4_s;
    logic [SQS_W-1:0]                   r4_side;

    logic                               sq_v;
    logic [ROOT_W-1:0]                  sq_root;
    logic [SQS_W-1:0]                   sq_side;

    logic                               r5_v;
    logic [COORD_W-1:0]                 r5_lc;
    logic [ROOT_W-1:0]                  r5_len;
    logic                               r5_zero;
    logic [LANES-1:0]                   r5_neg;
    logic [LANES-1:0][WM_W-1:0]         r5_wm;
    logic                               r6_v;
    logic [LANES-1:0][LO_W+COORD_W-1:0] r6_pl;
    logic [LANES-1:0][HI_PART_W+COORD_W-1:0] r6_ph;
    logic [ROOT_W-1:0]                  r6_len;
    logic                               r6_zero;
    logic [LANES-1:0]                   r6_neg;
    logic                               r7_v;
    logic [LANES-1:0][NUM_W-1:0]        r7_num;
    logic [ROOT_W-1:0]                  r7_len;
    logic                               r7_zero;
    logic [LANES-1:0]                   r7_neg;

    logic [LANES-1:0][QN_W-1:0]         dv_num;
    logic                               dv_v;
    logic [LANES-1:0][Q_W-1:0]          dv_mag;
    logic [LANES:0]                     dv_side;

    logic                               r_out_v;
    logic [LANES-1:0][COORD_W-1:0]      r_p0;
    logic [LANES-1:0][COORD_W-1:0]      r_p1;

    logic [ROOT_W-1:0] lc_lo;
    logic [ROOT_W-1:0] lc_hi;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rmin   <= '0;
            r_rmax   <= '1;
            r_weight <= WGT_W'(32'h0001_0000);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RANGE_MIN: r_rmin   <= i_cfg_data;
                REG_RANGE_MAX: r_rmax   <= i_cfg_data;
                REG_WEIGHT:    r_weight <= i_cfg_data[WGT_W-1:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_out_v || i_out_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= sq_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    // Front end: difference, magnitude, squares and weighted magnitudes, sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_d[0] <= {i_p1_x[31], i_p1_x} - {i_p0_x[31], i_p0_x};
            r1_d[1] <= {i_p1_y[31], i_p1_y} - {i_p0_y[31], i_p0_y};
            r1_d[2] <= {i_p1_z[31], i_p1_z} - {i_p0_z[31], i_p0_z};
            for (int l = 0; l < LANES; l++) begin
                r2_neg[l] <= r1_d[l][DIFF_W-1];
                r2_mag[l] <= r1_d[l][DIFF_W-1] ? (DIFF_W'(0) - r1_d[l]) : r1_d[l];
                r3_sq[l]  <= SQ_W'(r2_mag[l]) * SQ_W'(r2_mag[l]);
                r3_wm[l]  <= WM_W'(r_weight) * WM_W'(r2_mag[l]);
            end
            r3_neg  <= r2_neg;
            r4_s    <= r3_sq[0] + r3_sq[1] + r3_sq[2];
            r4_side <= {r3_neg, r3_wm};
        end
    end

    elcp_sqrt #(.SIDE_W(SQS_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_rad   (r4_s),
        .i_side  (r4_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Clamp: raise to range_min first, then lower to range_max.
    assign lc_lo = (sq_root > ROOT_W'(r_rmin)) ? sq_root : ROOT_W'(r_rmin);
    assign lc_hi = (lc_lo > ROOT_W'(r_rmax)) ? ROOT_W'(r_rmax) : lc_lo;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_lc   <= lc_hi[COORD_W-1:0];
            r5_len  <= sq_root;
            r5_zero <= (sq_root == '0);
            r5_neg  <= sq_side[SQS_W-1 -: LANES];
            r5_wm   <= sq_side[LANES*WM_W-1:0];
            // The 57x32 product is split into two partial products.
            for (int l = 0; l < LANES; l++) begin
                r6_pl[l] <= (LO_W+COORD_W)'(r5_wm[l][LO_W-1:0]) * (LO_W+COORD_W)'(r5_lc);
                r6_ph[l] <= (HI_PART_W+COORD_W)'(r5_wm[l][WM_W-1:LO_W])
                            * (HI_PART_W+COORD_W)'(r5_lc);
                r7_num[l] <= {r6_ph[l], {LO_W{1'b0}}} + NUM_W'(r6_pl[l]);
            end
            r6_len  <= r5_len;
            r6_zero <= r5_zero;
            r6_neg  <= r5_neg;
            r7_len  <= r6_len;
            r7_zero <= r6_zero;
            r7_neg  <= r6_neg;
        end
    end

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            dv_num[l] = r7_num[l][NUM_W-1:FRAC_SH];
        end
    end

    elcp_div #(.SIDE_W(LANES + 1)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_num   (dv_num),
        .i_den   (r7_len),
        .i_side  ({r7_neg, r7_zero}),
        .o_valid (dv_v),
        .o_mag   (dv_mag),
        .o_side  (dv_side)
    );

    // Output register: sign the magnitude and saturate each row.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [COORD_W-1:0] m;
        logic [COORD_W-1:0] pos;
        logic [COORD_W-1:0] ngv;
        if (en) begin
            for (int l = 0; l < LANES; l++) begin
                m   = dv_side[0] ? '0 : dv_mag[l];
                pos = (m == MAG_CAP) ? ~MAG_CAP : m;
                ngv = COORD_W'(0) - m;
                r_p1[l] <= dv_side[l+1] ? ngv : pos;
                r_p0[l] <= dv_side[l+1] ? pos : ngv;
            end
        end
    end

    assign o_out_valid = r_out_v;
    assign o_proj0_x   = r_p0[0];
    assign o_proj0_y   = r_p0[1];
    assign o_proj0_z   = r_p0[2];
    assign o_proj1_x   = r_p1[0];
    assign o_proj1_y   = r_p1[1];
    assign o_proj1_z   = r_p1[2];
endmodule

/* sv/elcp_checker.sv */
// Port-level checker for the edge length clamp projection block, with its bind.
module elcp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_proj0_x,
    input logic [31:0] o_proj1_x,
    input logic [31:0] o_proj0_z,
    input logic [31:0] o_proj1_z
);
`include "edge_length_clamp_projection_assert.svh"

    // A waiting result stays offered.
    `ELCP_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    // A zero second row on the x axis pairs with a zero first row.
    `ELCP_ASSERT_IMPLY(a_zero_pair, i_clk, i_rst_n, o_out_valid && (o_proj1_x == 32'd0), o_proj0_x == 32'd0)
    // A positive second row on the z axis pairs with a negative first row.
    `ELCP_ASSERT_IMPLY(a_sign_pair, i_clk, i_rst_n, o_out_valid && !o_proj1_z[31] && (o_proj1_z != 32'd0), o_proj0_z[31])
    // Reset empties the output register.
    `ELCP_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n), !o_out_valid)
endmodule

bind edge_length_clamp_projection elcp_checker u_elcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_proj0_x   (o_proj0_x),
    .o_proj1_x   (o_proj1_x),
    .o_proj0_z   (o_proj0_z),
    .o_proj1_z   (o_proj1_z)
);
